### src/sorted_bounded_list_table_defines.svh
// Assertion macros shared by the sorted bounded list table RTL.
`ifndef SORTED_BOUNDED_LIST_TABLE_DEFINES_SVH
`define SORTED_BOUNDED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sblt_pkg.sv
// Types and fixed field widths for the sorted bounded list table.
`timescale 1ns / 1ps
package sblt_pkg;

    localparam int ACTION_W   = 2;
    localparam int LINE_NUM_W = 6;
    localparam int BUS_ID_W   = 16;
    localparam int COUNT_W    = 3;
    localparam int ENTRY_W    = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD  = 2'd0,
        ACT_DEL  = 2'd1,
        ACT_LIST = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               ok;
        logic               bad_line;
        logic [COUNT_W-1:0] count;
        logic [ENTRY_W-1:0] entry_value;
        logic               entry_valid;
        logic               last;
    } t_result;

endpackage

### src/sblt_in_if.sv
// Request channel of the sorted bounded list table.
`timescale 1ns / 1ps
interface sblt_in_if;
    logic                               valid;
    logic                               ready;
    logic [sblt_pkg::ACTION_W-1:0]      action;
    logic [sblt_pkg::LINE_NUM_W-1:0]    line_number;
    logic [sblt_pkg::BUS_ID_W-1:0]      bus_id;

    modport source (output valid, action, line_number, bus_id, input ready);
    modport sink   (input valid, action, line_number, bus_id, output ready);
endinterface

### src/sblt_out_if.sv
// Result channel of the sorted bounded list table.
`timescale 1ns / 1ps
interface sblt_out_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic                           bad_line;
    logic [sblt_pkg::COUNT_W-1:0]   count;
    logic [sblt_pkg::ENTRY_W-1:0]   entry_value;
    logic                           entry_valid;
    logic                           last;

    modport source (output valid, ok, bad_line, count, entry_value, entry_valid, last,
                    input ready);
    modport sink   (input valid, ok, bad_line, count, entry_value, entry_valid, last,
                    output ready);
endinterface

### src/sblt_row_edit.sv
// Sorted insert and first-match delete on one line's slots.
`timescale 1ns / 1ps
module sblt_row_edit #(
    parameter int SLOTS   = 5,
    parameter int ID_BITS = 16,
    parameter int CNT_W   = 3
) (
    input  logic [SLOTS-1:0][ID_BITS-1:0] i_row,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [ID_BITS-1:0]            i_id,
    output logic [SLOTS-1:0][ID_BITS-1:0] o_add_row,
    output logic [SLOTS-1:0][ID_BITS-1:0] o_del_row,
    output logic                          o_found
);

    logic [SLOTS-1:0] lt;    // live slot holds a smaller id (a prefix, the list is sorted)
    logic [SLOTS-1:0] eq;    // live slot holds an equal id
    logic [SLOTS-1:0] seen;  // an equal id sits at or below this slot

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            lt[j] = (CNT_W'(j) < i_count) && (i_row[j] < i_id);
            eq[j] = (CNT_W'(j) < i_count) && (i_row[j] == i_id);
        end

        seen[0] = eq[0];
        for (int j = 1; j < SLOTS; j++) begin
            seen[j] = seen[j-1] | eq[j];
        end

        // insert: keep smaller ids, put the new id at the first not-smaller slot, shift up
        o_add_row[0] = lt[0] ? i_row[0] : i_id;
        for (int j = 1; j < SLOTS; j++) begin
            o_add_row[j] = lt[j] ? i_row[j] : (lt[j-1] ? i_id : i_row[j-1]);
        end

        // delete: from the first match upward, take the slot above
        for (int j = 0; j < SLOTS - 1; j++) begin
            o_del_row[j] = seen[j] ? i_row[j+1] : i_row[j];
        end
        o_del_row[SLOTS-1] = i_row[SLOTS-1];

        o_found = seen[SLOTS-1];
    end

endmodule

### src/sorted_bounded_list_table.sv
// Top level of the sorted bounded list table.
`timescale 1ns / 1ps
// Table of NUM_LINES one-based lines, each an ascending list of up to
// SLOTS_PER_LINE identifiers (duplicates allowed).
// i_in carries one request item: action (add, delete, list), line_number, bus_id.
// o_out carries result items: ok, bad_line, count, entry_value, entry_valid, last.
// Add, delete, unknown action and bad line numbers give one result item;
// a list gives one item per stored entry (or one for an empty line), last on the final.
// Each line lives in one row of a single-port-write memory, count beside the slots.
// An accepted item with a valid line reads its row at the accept edge; in ST_EXEC the
// block edits and writes the row back and loads the first result into the output
// register, once that register is free.
// A new item is taken only in ST_IDLE, after the read and write-back of the last one;
// a list emits one entry per cycle from a row copy while o_out.ready does not stall it.
// The next read always follows the write-back, so no forwarding is needed.
// Reset: control state clears, then a clearing pass over all NUM_LINES rows zeroes every
// row's count; i_in.ready stays low during the pass.
// Stall: the output register holds its item while o_out.ready is low, and the block
// waits with the edited row unwritten until the register can take the result.
`include "sorted_bounded_list_table_defines.svh"
module sorted_bounded_list_table #(
    parameter int NUM_LINES      = 32,
    parameter int SLOTS_PER_LINE = 5,
    parameter int ID_BITS        = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sblt_in_if.sink           i_in,
    sblt_out_if.source        o_out
);

    localparam int LINE_W  = $clog2(NUM_LINES > 1 ? NUM_LINES : 2);
    localparam int SLOT_W  = $clog2(SLOTS_PER_LINE > 1 ? SLOTS_PER_LINE : 2);
    localparam int CNT_W   = $clog2(SLOTS_PER_LINE + 1);
    localparam int ROW_W   = SLOTS_PER_LINE * ID_BITS;
    localparam int MEM_W   = CNT_W + ROW_W;
    localparam int COUNT_W = sblt_pkg::COUNT_W;
    localparam int ENTRY_W = sblt_pkg::ENTRY_W;

    typedef logic [SLOTS_PER_LINE-1:0][ID_BITS-1:0] t_row;

    // line memory: {count, slots}
    logic [MEM_W-1:0] r_mem [NUM_LINES];
    logic [MEM_W-1:0] r_rdata;

    sblt_pkg::t_state  r_state, n_state;
    logic [LINE_W-1:0] r_clr_idx;

    // item under work
    sblt_pkg::t_action  r_action;
    logic               r_bad;
    logic [LINE_W-1:0]  r_idx;
    logic [ID_BITS-1:0] r_id;

    // list emission
    t_row               r_list_row;
    logic [CNT_W-1:0]   r_list_cnt;
    logic [SLOT_W-1:0]  r_emit_idx, n_emit_idx;
    logic               list_load;

    // output register
    logic               r_out_valid;
    sblt_pkg::t_result  r_out, n_out;
    logic               out_load, out_free;

    // accept side
    logic               in_ready, in_accept, in_bad;
    logic [LINE_W-1:0]  in_idx;

    // memory write port
    logic               mem_we;
    logic [LINE_W-1:0]  wr_idx;
    logic [CNT_W-1:0]   wr_cnt;
    t_row               wr_row;

    // current row
    logic [CNT_W-1:0]   cur_cnt;
    t_row               cur_row;
    t_row               add_row, del_row;
    logic               del_found, full;

    assign in_ready  = (r_state == sblt_pkg::ST_IDLE);
    assign in_accept = i_in.valid && in_ready;
    assign in_bad    = (i_in.line_number == '0) || (32'(i_in.line_number) > NUM_LINES);
    assign in_idx    = LINE_W'(i_in.line_number - 1'b1);
    assign i_in.ready = in_ready;

    assign cur_cnt = r_rdata[MEM_W-1 -: CNT_W];
    assign cur_row = t_row'(r_rdata[ROW_W-1:0]);
    assign full    = (cur_cnt >= CNT_W'(SLOTS_PER_LINE));

    sblt_row_edit #(
        .SLOTS   (SLOTS_PER_LINE),
        .ID_BITS (ID_BITS),
        .CNT_W   (CNT_W)
    ) u_row_edit (
        .i_row     (cur_row),
        .i_count   (cur_cnt),
        .i_id      (r_id),
        .o_add_row (add_row),
        .o_del_row (del_row),
        .o_found   (del_found)
    );

    assign out_free = !r_out_valid || o_out.ready;

    // next state, memory write-back and result formation
    always_comb begin
        n_state    = r_state;
        mem_we     = 1'b0;
        wr_idx     = r_idx;
        wr_cnt     = cur_cnt;
        wr_row     = cur_row;
        out_load   = 1'b0;
        list_load  = 1'b0;
        n_emit_idx = r_emit_idx;
        n_out      = '0;
        n_out.last = 1'b1;

        unique case (r_state)
            sblt_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                wr_idx = r_clr_idx;
                wr_cnt = '0;
                wr_row = '0;
                if (r_clr_idx == LINE_W'(NUM_LINES - 1)) begin
                    n_state = sblt_pkg::ST_IDLE;
                end
            end
            sblt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = sblt_pkg::ST_EXEC;
                end
            end
            sblt_pkg::ST_EXEC: begin
                if (r_bad) begin
                    n_out.bad_line = 1'b1;
                end else begin
                    n_out.count = COUNT_W'(cur_cnt);
                    unique case (r_action)
                        sblt_pkg::ACT_ADD: begin
                            if (!full) begin
                                wr_cnt      = cur_cnt + 1'b1;
                                wr_row      = add_row;
                                mem_we      = out_free;
                                n_out.ok    = 1'b1;
                                n_out.count = COUNT_W'(wr_cnt);
                            end
                        end
                        sblt_pkg::ACT_DEL: begin
                            if (del_found) begin
                                wr_cnt      = cur_cnt - 1'b1;
                                wr_row      = del_row;
                                mem_we      = out_free;
                                n_out.ok    = 1'b1;
                                n_out.count = COUNT_W'(wr_cnt);
                            end
                        end
                        sblt_pkg::ACT_LIST: begin
                            n_out.ok = 1'b1;
                            if (cur_cnt != '0) begin
                                n_out.entry_value = ENTRY_W'(cur_row[0]);
                                n_out.entry_valid = 1'b1;
                                n_out.last        = (cur_cnt == CNT_W'(1));
                            end
                        end
                        sblt_pkg::ACT_NOP: begin
                        end
                    endcase
                end
                if (out_free) begin
                    out_load = 1'b1;
                    if (!n_out.last) begin
                        list_load  = 1'b1;
                        n_emit_idx = SLOT_W'(1);
                        n_state    = sblt_pkg::ST_EMIT;
                    end else begin
                        n_state = sblt_pkg::ST_IDLE;
                    end
                end
            end
            sblt_pkg::ST_EMIT: begin
                n_out.ok          = 1'b1;
                n_out.count       = COUNT_W'(r_list_cnt);
                n_out.entry_value = ENTRY_W'(r_list_row[r_emit_idx]);
                n_out.entry_valid = 1'b1;
                n_out.last        = (CNT_W'(r_emit_idx) + CNT_W'(1) == r_list_cnt);
                if (out_free) begin
                    out_load   = 1'b1;
                    n_emit_idx = r_emit_idx + 1'b1;
                    if (n_out.last) begin
                        n_state = sblt_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sblt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (r_state == sblt_pkg::ST_CLEAR) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // line memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= {wr_cnt, ROW_W'(wr_row)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && !in_bad) begin
            r_rdata <= r_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= sblt_pkg::t_action'(i_in.action);
            r_bad    <= in_bad;
            r_idx    <= in_idx;
            r_id     <= ID_BITS'(i_in.bus_id);
        end
        if (list_load) begin
            r_list_row <= cur_row;
            r_list_cnt <= cur_cnt;
        end
        r_emit_idx <= n_emit_idx;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_out.ok;
    assign o_out.bad_line    = r_out.bad_line;
    assign o_out.count       = r_out.count;
    assign o_out.entry_value = r_out.entry_value;
    assign o_out.entry_valid = r_out.entry_valid;
    assign o_out.last        = r_out.last;

    `SBLT_ASSERT_NOW(a_bad_no_write, i_clk, i_rst_n, (r_state == sblt_pkg::ST_EXEC) && r_bad, !mem_we, "bad line wrote the memory")
    `SBLT_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, mem_we, wr_cnt <= CNT_W'(SLOTS_PER_LINE), "line count over capacity")
    `SBLT_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, r_state == sblt_pkg::ST_CLEAR, !r_out_valid && !in_ready, "activity during clearing pass")
    `SBLT_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, out_load && n_out.last, r_state == sblt_pkg::ST_IDLE, "not idle after final result")

endmodule

### test/tb_top.sv
// Self-checking testbench for the sorted bounded list table.
`timescale 1ns / 1ps
module tb_top;

    localparam int NUM_LINES      = 32;
    localparam int SLOTS_PER_LINE = 5;
    localparam int ID_BITS        = 16;
    localparam int STUCK_LIMIT    = 3000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int PRINT_CAP      = 100;

    localparam int LINE_NUM_W = sblt_pkg::LINE_NUM_W;
    localparam int BUS_ID_W   = sblt_pkg::BUS_ID_W;
    localparam int COUNT_W    = sblt_pkg::COUNT_W;
    localparam int ENTRY_W    = sblt_pkg::ENTRY_W;

    typedef struct packed {
        sblt_pkg::t_action       act;
        logic [LINE_NUM_W-1:0]   line;
        logic [BUS_ID_W-1:0]     id;
    } t_line_req;

    logic i_clk;
    logic i_rst_n;

    sblt_in_if  req_ch ();
    sblt_out_if rsp_ch ();

    sorted_bounded_list_table #(
        .NUM_LINES      (NUM_LINES),
        .SLOTS_PER_LINE (SLOTS_PER_LINE),
        .ID_BITS        (ID_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    // Shadow copy of the table, updated as each request item is accepted.
    logic [COUNT_W-1:0]  line_fill [NUM_LINES];
    logic [ID_BITS-1:0]  line_ids  [NUM_LINES][SLOTS_PER_LINE];

    t_line_req          pending_reqs[$];
    sblt_pkg::t_result  expected_results[$];
    t_line_req          offered_req;
    logic [BUS_ID_W-1:0] id_pool [8];

    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    bit            hold_request;
    int unsigned   hold_left;
    int unsigned   stuck_cycles;
    int unsigned   error_total;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        if (error_total < PRINT_CAP)
            $display("result check at %0t: %s", $realtime, msg);
        error_total++;
    endtask

    // Expected results of one accepted request; updates the shadow table.
    function automatic void predict_results(input t_line_req rq);
        sblt_pkg::t_result r;
        int unsigned       idx, n, pos, i;
        r      = '0;
        r.last = 1'b1;
        if (rq.line == 0 || rq.line > NUM_LINES) begin
            r.bad_line = 1'b1;
            expected_results.push_back(r);
            return;
        end
        idx = rq.line - 1;
        n   = line_fill[idx];
        case (rq.act)
            sblt_pkg::ACT_ADD: begin
                if (n < SLOTS_PER_LINE) begin
                    // new id lands before the first entry not smaller than it
                    pos = 0;
                    while (pos < n && line_ids[idx][pos] < rq.id) pos++;
                    for (i = n; i > pos; i--) line_ids[idx][i] = line_ids[idx][i-1];
                    line_ids[idx][pos] = rq.id;
                    n++;
                    line_fill[idx] = COUNT_W'(n);
                    r.ok = 1'b1;
                end
                r.count = COUNT_W'(n);
                expected_results.push_back(r);
            end
            sblt_pkg::ACT_DEL: begin
                pos = 0;
                while (pos < n && line_ids[idx][pos] != rq.id) pos++;
                if (pos < n) begin
                    for (i = pos; i + 1 < n; i++) line_ids[idx][i] = line_ids[idx][i+1];
                    n--;
                    line_fill[idx] = COUNT_W'(n);
                    r.ok = 1'b1;
                end
                r.count = COUNT_W'(n);
                expected_results.push_back(r);
            end
            sblt_pkg::ACT_LIST: begin
                r.ok = 1'b1;
                if (n == 0) begin
                    expected_results.push_back(r);
                end else begin
                    for (i = 0; i < n; i++) begin
                        r.count       = COUNT_W'(n);
                        r.entry_value = ENTRY_W'(line_ids[idx][i]);
                        r.entry_valid = 1'b1;
                        r.last        = (i + 1 == n);
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
                r.count = COUNT_W'(n);
                expected_results.push_back(r);
            end
        endcase
    endfunction

    task automatic queue_request(input sblt_pkg::t_action a, input int unsigned ln,
                                 input int unsigned id);
        t_line_req rq;
        rq.act  = a;
        rq.line = LINE_NUM_W'(ln);
        rq.id   = BUS_ID_W'(id);
        pending_reqs.push_back(rq);
    endtask

    // Mostly valid lines, a few hot lines so they fill up, ids mostly from a
    // small pool so deletes find their entries.
    task automatic queue_random_requests(input int unsigned how_many);
        int unsigned       k, roll, ln, id;
        sblt_pkg::t_action a;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (k = 2; k < 8; k++) id_pool[k] = BUS_ID_W'($urandom);
        for (k = 0; k < how_many; k++) begin
            roll = $urandom_range(99);
            if (roll < 40)      a = sblt_pkg::ACT_ADD;
            else if (roll < 75) a = sblt_pkg::ACT_DEL;
            else if (roll < 96) a = sblt_pkg::ACT_LIST;
            else                a = sblt_pkg::ACT_NOP;
            roll = $urandom_range(99);
            if (roll < 5)       ln = $urandom_range(1) ? 0 : $urandom_range(33, 63);
            else if (roll < 60) ln = $urandom_range(1, 4);
            else                ln = $urandom_range(1, NUM_LINES);
            id = ($urandom_range(99) < 70) ? id_pool[$urandom_range(7)] : $urandom;
            queue_request(a, ln, id);
        end
    endtask

    task automatic wait_until_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: holds an offered item until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_results(offered_req);
            end
            if (req_ch.valid && !req_ch.ready) begin
                // still offered, keep everything as is
            end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_req         = pending_reqs.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.action      <= offered_req.act;
                req_ch.line_number <= offered_req.line;
                req_ch.bus_id      <= offered_req.id;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin : result_check
        sblt_pkg::t_result got, want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.ok          = rsp_ch.ok;
                got.bad_line    = rsp_ch.bad_line;
                got.count       = rsp_ch.count;
                got.entry_value = rsp_ch.entry_value;
                got.entry_valid = rsp_ch.entry_valid;
                got.last        = rsp_ch.last;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("unexpected result item %h", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok)
                        flag_error($sformatf("ok %b, want %b", got.ok, want.ok));
                    if (got.bad_line !== want.bad_line)
                        flag_error($sformatf("bad_line %b, want %b", got.bad_line,
                                             want.bad_line));
                    if (got.count !== want.count)
                        flag_error($sformatf("count %0d, want %0d", got.count, want.count));
                    if (got.entry_value !== want.entry_value)
                        flag_error($sformatf("entry_value %h, want %h", got.entry_value,
                                             want.entry_value));
                    if (got.entry_valid !== want.entry_valid)
                        flag_error($sformatf("entry_valid %b, want %b", got.entry_valid,
                                             want.entry_valid));
                    if (got.last !== want.last)
                        flag_error($sformatf("last %b, want %b", got.last, want.last));
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: no item moving on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_request       = 1'b0;
        error_total        = 0;
        for (int k = 0; k < NUM_LINES; k++) line_fill[k] = '0;

        // Directed: empty list, bad lines, unknown action, fill / overflow,
        // duplicates, absent delete, list of a full line.
        queue_request(sblt_pkg::ACT_LIST, 1, 16'h0000);
        queue_request(sblt_pkg::ACT_ADD, 0, 16'h1111);
        queue_request(sblt_pkg::ACT_DEL, 33, 16'h1111);
        queue_request(sblt_pkg::ACT_LIST, 63, 16'h0000);
        queue_request(sblt_pkg::ACT_NOP, 0, 16'h0000);
        queue_request(sblt_pkg::ACT_NOP, 7, 16'hFFFF);
        queue_request(sblt_pkg::ACT_ADD, 32, 16'hFFFF);
        queue_request(sblt_pkg::ACT_ADD, 32, 16'h0000);
        queue_request(sblt_pkg::ACT_ADD, 32, 16'h8000);
        queue_request(sblt_pkg::ACT_ADD, 32, 16'h8000);
        queue_request(sblt_pkg::ACT_ADD, 32, 16'h1234);
        queue_request(sblt_pkg::ACT_ADD, 32, 16'h0001);
        queue_request(sblt_pkg::ACT_LIST, 32, 16'hFFFF);
        queue_request(sblt_pkg::ACT_NOP, 32, 16'h0000);
        queue_request(sblt_pkg::ACT_DEL, 32, 16'h8000);
        queue_request(sblt_pkg::ACT_DEL, 32, 16'h4321);
        queue_request(sblt_pkg::ACT_LIST, 32, 16'h0000);
        queue_request(sblt_pkg::ACT_DEL, 32, 16'hFFFF);
        queue_request(sblt_pkg::ACT_DEL, 32, 16'h0000);
        queue_request(sblt_pkg::ACT_ADD, 1, 16'hAAAA);
        queue_request(sblt_pkg::ACT_ADD, 1, 16'h5555);
        queue_request(sblt_pkg::ACT_DEL, 1, 16'h5555);
        queue_request(sblt_pkg::ACT_LIST, 1, 16'h0000);
        queue_request(sblt_pkg::ACT_DEL, 7, 16'h0000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        wait_until_drained();

        // random phases; each waits for every result before the next
        queue_random_requests(75);
        wait_until_drained();

        send_idle_pct = 71;
        queue_random_requests(75);
        wait_until_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 71;
        queue_random_requests(75);
        wait_until_drained();

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        queue_random_requests(75);
        wait_until_drained();

        // receiver holds off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        while (hold_left == 0) @(negedge i_clk);
        hold_request = 1'b0;
        queue_random_requests(20);
        wait_until_drained();

        repeat (20) @(negedge i_clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d result items never arrived", expected_results.size()));
        if (error_total == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
